// File: rtl/sbus_frame_receiver_decoder_macros.svh
// assertion helpers for the sbus frame receiver
`ifndef SBUS_FRAME_RECEIVER_DECODER_MACROS_SVH
`define SBUS_FRAME_RECEIVER_DECODER_MACROS_SVH

// same-cycle implication
`define SFRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfrd assertion failed");

// next-cycle implication
`define SFRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfrd assertion failed");

`endif

// File: rtl/sfrd_pkg.sv
package sfrd_pkg;

    localparam int ANALOG_CHANNELS = 16;

    localparam logic [4:0] FRAME_LEN    = 5'd25;
    localparam logic [4:0] COUNT_OVF    = 5'd26;
    localparam logic [4:0] FLAGS_POS    = 5'd23;
    localparam logic [4:0] END_POS      = 5'd24;
    localparam logic [4:0] HEADER_POS   = 5'd0;
    localparam logic [4:0] DATA_FIRST   = 5'd1;
    localparam logic [7:0] FRAME_HEADER = 8'h0F;
    localparam logic [7:0] FRAME_END    = 8'h00;

    localparam int CH_BITS   = 11;
    localparam int BUF_BITS  = 18;
    localparam int PROD_BITS = 27;
    localparam int Q_SHIFT   = 15;
    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(16384);

    localparam logic [4:0]  DIGITAL_MIN_N = 5'd16;
    localparam logic [4:0]  DIG_CH_FIRST  = 5'd16;
    localparam logic [4:0]  DIG_CH_LAST   = 5'd17;
    localparam logic [12:0] DIGITAL_LOW   = 13'd998;
    localparam logic [12:0] DIGITAL_HIGH  = 13'(998 + 1000);
    localparam int FS_BIT   = 3;
    localparam int LOST_BIT = 2;

    localparam logic [1:0] REG_GAP    = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;
    localparam logic [1:0] REG_CHANS  = 2'd3;

    localparam logic [7:0]  GAP_RST    = 8'd2;
    localparam logic [15:0] SCALE_RST  = 16'd20480;
    localparam logic [11:0] OFFSET_RST = 12'd880;
    localparam logic [4:0]  CHANS_RST  = 5'd18;

    typedef struct packed {
        logic take;
        logic append;
        logic extract;
        logic scale;
        logic digital;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic decode_go;
        logic bits_ok;
        logic analog_more;
        logic digital_more;
        logic out_fire;
    } t_dp_sts;

endpackage

// File: rtl/sfrd_dp.sv
module sfrd_dp
    import sfrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_arrival_ms,
    input  logic [7:0]  i_gap_threshold_ms,
    input  logic [15:0] i_scale_factor,
    input  logic [11:0] i_scale_offset,
    input  logic [4:0]  i_channels_out,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [4:0]  o_channel_index,
    output logic [12:0] o_channel_value,
    output logic        o_failsafe,
    output logic        o_frame_lost,
    output logic        o_last
);

    logic [7:0]           r_mem [FRAME_LEN];
    logic [7:0]           r_rdata;
    logic [4:0]           r_count;
    logic [31:0]          r_last_arrival;
    logic [7:0]           r_hdr;
    logic [7:0]           r_flags;
    logic [7:0]           r_end;
    logic [7:0]           r_pend_byte;
    logic                 r_pend_restart;
    logic [BUF_BITS-1:0]  r_bitbuf;
    logic [4:0]           r_bitcnt;
    logic [4:0]           r_rd_idx;
    logic [4:0]           r_ch;
    logic [PROD_BITS-1:0] r_prod;
    logic                 r_out_valid;
    logic [4:0]           r_out_index;
    logic [12:0]          r_out_value;
    logic                 r_out_fs;
    logic                 r_out_lost;
    logic                 r_out_last;

    logic [4:0]           n_eff;
    logic                 digital;
    logic                 boundary;
    logic                 frame_ok;
    logic [4:0]           count_eff;
    logic                 store_wr;
    logic [BUF_BITS-1:0]  n_bitbuf;
    logic [PROD_BITS:0]   rounded;
    logic [12:0]          n_value;
    logic                 dig_bit;

    assign n_eff    = (i_channels_out > 5'(ANALOG_CHANNELS)) ? 5'(ANALOG_CHANNELS)
                                                              : i_channels_out;
    assign digital  = (n_eff >= DIGITAL_MIN_N);
    assign boundary = (i_arrival_ms - r_last_arrival) > {24'd0, i_gap_threshold_ms};
    assign frame_ok = (r_count == FRAME_LEN) && (r_hdr == FRAME_HEADER)
                      && (r_end == FRAME_END);

    assign count_eff = r_pend_restart ? 5'd0 : r_count;
    assign store_wr  = i_cmd.commit && (count_eff < FRAME_LEN);

    assign n_bitbuf = r_bitbuf | (BUF_BITS'(r_rdata) << r_bitcnt);
    assign rounded  = (PROD_BITS + 1)'(r_prod) + ROUND_HALF;
    assign n_value  = 13'(rounded[PROD_BITS:Q_SHIFT]) + 13'(i_scale_offset);
    assign dig_bit  = (r_ch == DIG_CH_FIRST) ? r_flags[0] : r_flags[1];

    assign o_sts.decode_go    = boundary && frame_ok && (n_eff != 5'd0);
    assign o_sts.bits_ok      = (r_bitcnt >= 5'(CH_BITS));
    assign o_sts.analog_more  = (r_ch < n_eff);
    assign o_sts.digital_more = digital && (r_ch <= DIG_CH_LAST);
    assign o_sts.out_fire     = r_out_valid && i_out_ready;

    // frame store, registered read
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_mem[count_eff] <= r_pend_byte;
        end
        r_rdata <= r_mem[r_rd_idx];
    end

    // shadow copies of the fixed-position bytes, plus the pending byte, the product and the output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_byte <= i_rx_byte;
        end
        if (store_wr) begin
            if (count_eff == HEADER_POS) begin
                r_hdr <= r_pend_byte;
            end
            if (count_eff == FLAGS_POS) begin
                r_flags <= r_pend_byte;
            end
            if (count_eff == END_POS) begin
                r_end <= r_pend_byte;
            end
        end
        if (i_cmd.extract) begin
            r_prod <= PROD_BITS'(r_bitbuf[CH_BITS-1:0]) * PROD_BITS'(i_scale_factor);
        end
        if (i_cmd.scale) begin
            r_out_index <= r_ch;
            r_out_value <= n_value;
            r_out_fs    <= r_flags[FS_BIT];
            r_out_lost  <= r_flags[FS_BIT] | r_flags[LOST_BIT];
            r_out_last  <= (r_ch == 5'(n_eff - 5'd1)) && !digital;
        end else if (i_cmd.digital) begin
            r_out_index <= r_ch;
            r_out_value <= dig_bit ? DIGITAL_HIGH : DIGITAL_LOW;
            r_out_fs    <= r_flags[FS_BIT];
            r_out_lost  <= r_flags[FS_BIT] | r_flags[LOST_BIT];
            r_out_last  <= (r_ch == DIG_CH_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_last_arrival <= '0;
            r_pend_restart <= 1'b0;
            r_bitbuf       <= '0;
            r_bitcnt       <= '0;
            r_rd_idx       <= DATA_FIRST;
            r_ch           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_last_arrival <= i_arrival_ms;
                r_pend_restart <= boundary;
                r_bitbuf       <= '0;
                r_bitcnt       <= '0;
                r_rd_idx       <= DATA_FIRST;
                r_ch           <= '0;
            end
            if (i_cmd.append) begin
                r_bitbuf <= n_bitbuf;
                r_bitcnt <= r_bitcnt + 5'd8;
                r_rd_idx <= r_rd_idx + 5'd1;
            end
            if (i_cmd.extract) begin
                r_bitbuf <= r_bitbuf >> CH_BITS;
                r_bitcnt <= r_bitcnt - 5'(CH_BITS);
            end
            if (i_cmd.scale || i_cmd.digital) begin
                r_ch        <= r_ch + 5'd1;
                r_out_valid <= 1'b1;
            end else if (o_sts.out_fire) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_count <= (count_eff < FRAME_LEN) ? count_eff + 5'd1 : COUNT_OVF;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_failsafe      = r_out_fs;
    assign o_frame_lost    = r_out_lost;
    assign o_last          = r_out_last;

endmodule

// File: rtl/sfrd_ctrl.sv
module sfrd_ctrl
    import sfrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_RD,
        S_APP,
        S_EXT,
        S_SCL,
        S_WAIT,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_sts.decode_go ? S_NEXT : S_COMMIT;
                end
            end
            S_NEXT: begin
                if (i_sts.analog_more) begin
                    n_state = i_sts.bits_ok ? S_EXT : S_RD;
                end else if (i_sts.digital_more) begin
                    o_cmd.digital = 1'b1;
                    n_state       = S_WAIT;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_RD: begin
                n_state = S_APP;
            end
            S_APP: begin
                o_cmd.append = 1'b1;
                n_state      = S_NEXT;
            end
            S_EXT: begin
                o_cmd.extract = 1'b1;
                n_state       = S_SCL;
            end
            S_SCL: begin
                o_cmd.scale = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.out_fire) begin
                    n_state = S_NEXT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/sbus_frame_receiver_decoder.sv
// a byte that closes no good frame is accepted, then stored
// a boundary byte after a good frame decodes it: each data byte is read from the
// frame store and appended to the bit buffer, each analog channel is extracted,
// scaled and output, each digital channel is output; results come one at a time
// a new byte is taken only once the last one is stored; no new byte during a decode
// reset: synchronous active-low, clears byte count and last stamp, restores registers
`include "sbus_frame_receiver_decoder_macros.svh"

module sbus_frame_receiver_decoder
    import sfrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // rx_byte[7:0], arrival_ms[39:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // channel_index[4:0], channel_value[17:5], zero pad
    output logic [1:0]  m_axis_tuser,   // failsafe[0], frame_lost[1]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  r_gap_thr;
    logic [15:0] r_scale_factor;
    logic [11:0] r_scale_offset;
    logic [4:0]  r_channels_out;

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic        cfg_wr;
    logic [1:0]  reg_idx;
    logic [4:0]  out_index;
    logic [12:0] out_value;
    logic        out_fs;
    logic        out_lost;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_thr      <= GAP_RST;
            r_scale_factor <= SCALE_RST;
            r_scale_offset <= OFFSET_RST;
            r_channels_out <= CHANS_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_GAP:    r_gap_thr      <= pwdata[7:0];
                REG_SCALE:  r_scale_factor <= pwdata[15:0];
                REG_OFFSET: r_scale_offset <= pwdata[11:0];
                REG_CHANS:  r_channels_out <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAP:    prdata = {24'd0, r_gap_thr};
            REG_SCALE:  prdata = {16'd0, r_scale_factor};
            REG_OFFSET: prdata = {20'd0, r_scale_offset};
            REG_CHANS:  prdata = {27'd0, r_channels_out};
            default:    prdata = '0;
        endcase
    end

    sfrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sfrd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_rx_byte          (s_axis_tdata[7:0]),
        .i_arrival_ms       (s_axis_tdata[39:8]),
        .i_gap_threshold_ms (r_gap_thr),
        .i_scale_factor     (r_scale_factor),
        .i_scale_offset     (r_scale_offset),
        .i_channels_out     (r_channels_out),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_channel_index    (out_index),
        .o_channel_value    (out_value),
        .o_failsafe         (out_fs),
        .o_frame_lost       (out_lost),
        .o_last             (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_value, out_index};
    assign m_axis_tuser = {out_lost, out_fs};

    `SFRD_ASSERT_NOW(a_no_input_while_output, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `SFRD_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
    `SFRD_ASSERT_NOW(a_index_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[4:0] <= DIG_CH_LAST)
    `SFRD_ASSERT_NOW(a_failsafe_implies_lost, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[1])

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sfrd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 200;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [4:0]  index;
        logic [12:0] value;
        logic        failsafe;
        logic        frame_lost;
        logic        last;
    } chan_result_t;

    typedef enum int {FR_GOOD, FR_SHORT, FR_LONG, FR_BAD_HEADER, FR_BAD_END} frame_kind_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // rx_byte[7:0], arrival_ms[39:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // channel_index[4:0], channel_value[17:5], zero pad
    logic [1:0]  m_axis_tuser;         // failsafe[0], frame_lost[1]
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the receiver state and its registers
    logic [7:0]  frame_shadow [0:24];
    logic [4:0]  shadow_count = '0;
    logic [31:0] shadow_last_ms = '0;
    logic [7:0]  gap_ms = GAP_RST;
    logic [15:0] gain_q15 = SCALE_RST;
    logic [11:0] chan_offset = OFFSET_RST;
    logic [4:0]  chans_wanted = CHANS_RST;
    chan_result_t channel_q [$];

    logic [7:0]  frame_buf [0:31];
    int          frame_len;
    logic [31:0] now_ms = '0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          errors = 0;
    int          bytes_sent = 0;
    int          frames_decoded = 0;
    int          results_checked = 0;

    sbus_frame_receiver_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void decode_shadow_frame();
        logic [175:0] payload;
        logic [7:0]   flags;
        logic [4:0]   n;
        logic [10:0]  raw;
        logic [31:0]  scaled;
        int           total;
        chan_result_t r;
        for (int k = 0; k < 22; k++) payload[k*8 +: 8] = frame_shadow[k + 1];
        flags = frame_shadow[FLAGS_POS];
        n = (chans_wanted > ANALOG_CHANNELS) ? 5'(ANALOG_CHANNELS) : chans_wanted;
        total = (n >= DIGITAL_MIN_N) ? int'(n) + 2 : int'(n);
        r.failsafe = flags[FS_BIT];
        r.frame_lost = flags[FS_BIT] | flags[LOST_BIT];
        for (int ch = 0; ch < int'(n); ch++) begin
            raw = payload[ch*11 +: 11];
            scaled = ((32'(raw) * 32'(gain_q15) + 32'(ROUND_HALF)) >> Q_SHIFT)
                     + 32'(chan_offset);
            r.index = 5'(ch);
            r.value = scaled[12:0];
            r.last = (ch + 1 == total);
            channel_q.push_back(r);
        end
        if (n >= DIGITAL_MIN_N) begin
            r.index = DIG_CH_FIRST;
            r.value = flags[0] ? DIGITAL_HIGH : DIGITAL_LOW;
            r.last = 1'b0;
            channel_q.push_back(r);
            r.index = DIG_CH_LAST;
            r.value = flags[1] ? DIGITAL_HIGH : DIGITAL_LOW;
            r.last = 1'b1;
            channel_q.push_back(r);
        end
        frames_decoded++;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic [31:0] stamp);
        logic [31:0] gap;
        gap = stamp - shadow_last_ms;
        if (gap > 32'(gap_ms)) begin
            if (shadow_count == FRAME_LEN && frame_shadow[HEADER_POS] == FRAME_HEADER &&
                frame_shadow[END_POS] == FRAME_END) begin
                decode_shadow_frame();
            end
            shadow_count = '0;
        end
        shadow_last_ms = stamp;
        if (shadow_count < FRAME_LEN) begin
            frame_shadow[shadow_count] = b;
            shadow_count = shadow_count + 5'd1;
        end else begin
            shadow_count = COUNT_OVF;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_checked, what, got, want);
        errors++;
    endtask

    always @(negedge i_clk) begin
        chan_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (channel_q.size() == 0) begin
                report_mismatch("unexpected channel", m_axis_tdata[4:0], -1);
            end else begin
                want = channel_q.pop_front();
                if (m_axis_tdata[4:0] != want.index)
                    report_mismatch("channel_index", m_axis_tdata[4:0], want.index);
                if (m_axis_tdata[17:5] != want.value)
                    report_mismatch("channel_value", m_axis_tdata[17:5], want.value);
                if (m_axis_tuser[0] != want.failsafe)
                    report_mismatch("failsafe", m_axis_tuser[0], want.failsafe);
                if (m_axis_tuser[1] != want.frame_lost)
                    report_mismatch("frame_lost", m_axis_tuser[1], want.frame_lost);
                if (m_axis_tlast != want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

    // output ready, with a counted hold-off for back-pressure
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [31:0] stamp);
        logic fired;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {stamp, b};
        fired = 1'b0;
        while (!fired) begin
            @(negedge i_clk);
            fired = s_axis_tready;
            if (fired) predict_byte(b, stamp);
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GAP:    gap_ms = val[7:0];
            REG_SCALE:  gain_q15 = val[15:0];
            REG_OFFSET: chan_offset = val[11:0];
            REG_CHANS:  chans_wanted = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [15:0] gain,
                              input logic [11:0] ofs, input logic [4:0] chans);
        write_reg(REG_GAP, 32'(thr));
        write_reg(REG_SCALE, 32'(gain));
        write_reg(REG_OFFSET, 32'(ofs));
        write_reg(REG_CHANS, 32'(chans));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (channel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // gap past the threshold, sometimes huge so the stamp wraps or runs backward
    function automatic logic [31:0] boundary_stamp();
        logic [31:0] gap;
        if ($urandom_range(3) == 0) gap = $urandom;
        else gap = 32'(gap_ms) + 32'd1 + $urandom_range(20);
        if (gap <= 32'(gap_ms)) gap = 32'(gap_ms) + 32'd1;
        now_ms = now_ms + gap;
        return now_ms;
    endfunction

    function automatic logic [31:0] frame_stamp();
        now_ms = now_ms + $urandom_range(gap_ms);
        return now_ms;
    endfunction

    function automatic void build_frame(input frame_kind_t kind);
        frame_len = 25;
        frame_buf[HEADER_POS] = FRAME_HEADER;
        for (int k = 1; k < 32; k++) frame_buf[k] = pick_byte();
        frame_buf[END_POS] = FRAME_END;
        case (kind)
            FR_SHORT:      frame_len = $urandom_range(1, 24);
            FR_LONG:       frame_len = $urandom_range(26, 32);
            FR_BAD_HEADER: frame_buf[HEADER_POS] = FRAME_HEADER ^ 8'($urandom_range(1, 255));
            FR_BAD_END:    frame_buf[END_POS] = 8'($urandom_range(1, 255));
            default: ;
        endcase
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        build_frame(kind);
        for (int k = 0; k < frame_len; k++)
            send_byte(frame_buf[k], (k == 0) ? boundary_stamp() : frame_stamp());
    endtask

    // a good frame, a broken one, then random kinds; a lone byte closes the last
    task automatic run_frames(input int n_frames, input frame_kind_t broken);
        frame_kind_t kind;
        for (int f = 0; f < n_frames; f++) begin
            if (f == 0) kind = FR_GOOD;
            else if (f == 1) kind = broken;
            else if ($urandom_range(9) < 6) kind = FR_GOOD;
            else kind = frame_kind_t'($urandom_range(1, 4));
            send_frame(kind);
        end
        send_byte(pick_byte(), boundary_stamp());
        wait_drained();
    endtask

    task automatic test_default_frame();
        send_idle_pct = 0;
        stall_pct = 0;
        now_ms = 32'hFFFF_FFF0;
        for (int k = 0; k < 25; k++) begin
            if (k == HEADER_POS) frame_buf[k] = FRAME_HEADER;
            else if (k <= 11) frame_buf[k] = 8'hFF;
            else if (k == FLAGS_POS) frame_buf[k] = 8'h0F;
            else frame_buf[k] = 8'h00;
            send_byte(frame_buf[k], (k == 0) ? boundary_stamp() : frame_stamp());
        end
        // stamp going backward still reads as a long gap
        now_ms = now_ms - 32'd1000;
        send_byte(8'h5A, now_ms);
        wait_drained();
    endtask

    task automatic test_gain_extremes();
        send_idle_pct = 0;
        stall_pct = 0;
        set_config(8'd0, 16'hFFFF, 12'hFFF, 5'd18);
        run_frames(3, FR_LONG);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 86;
        stall_pct = 0;
        set_config(8'd255, 16'd0, 12'd0, 5'd16);
        run_frames(2, FR_BAD_HEADER);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        stall_pct = 86;
        set_config(8'($urandom), 16'($urandom), 12'($urandom), 5'd15);
        run_frames(2, FR_BAD_END);
    endtask

    task automatic test_channel_counts();
        send_idle_pct = 6;
        stall_pct = 6;
        set_config(8'($urandom_range(1, 40)), 16'($urandom), 12'($urandom), 5'd0);
        run_frames(1, FR_GOOD);
        write_reg(REG_CHANS, 32'd31);
        run_frames(1, FR_GOOD);
        write_reg(REG_CHANS, 32'd1);
        run_frames(2, FR_SHORT);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        set_config(GAP_RST, SCALE_RST, OFFSET_RST, CHANS_RST);
        send_frame(FR_GOOD);
        hold_left <= HOLD_OFF_CYCLES;
        send_frame(FR_GOOD);
        send_byte(pick_byte(), boundary_stamp());
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_frame();
        test_gain_extremes();
        test_sender_gaps();
        test_receiver_stalls();
        test_channel_counts();
        test_output_backpressure();
        $display("sent %0d bytes, %0d frames decoded, %0d channel results compared",
                 bytes_sent, frames_decoded, results_checked);
        $display("gap, gain, offset and channel count extremes, broken and overlong frames,");
        $display("stamp wrap, four idle mixes and a long output hold-off");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
